// ===== hw/rtl/fphms_pkg.sv =====
// ----------------------------------------------------------------------------
// fphms_pkg
// Shared types and constants of the polar histogram mode filter.
// ----------------------------------------------------------------------------
package fphms_pkg;

    localparam int DEF_MAX_PAIRS  = 64;
    localparam int DEF_HIST_DEPTH = 2048;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 15;

    localparam int MAG_W   = 17;
    localparam int ANG_W   = 15;
    localparam int CNT_W   = 7;
    localparam int NUM_W   = 23;
    localparam int QUO_W   = 8;
    localparam int BIN_W   = 11;
    localparam int IDX_W   = 6;

    localparam logic [4:0]  RST_DIST_BINS  = 5'd10;
    localparam logic [7:0]  RST_ANGLE_BINS = 8'd90;
    localparam logic [14:0] RST_ANGLE_LOW  = 15'd0;
    localparam logic [14:0] RST_ANGLE_HIGH = 15'd23040;

    localparam int CORDIC_STEPS = 16;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [16:0] MAG_MAX_CODE = 17'd131071;
    localparam logic [14:0] ANGLE_MAX_CODE = 15'd23040;
    localparam logic [14:0] ZERO_DISP_ANGLE = 15'd11520;
    localparam logic [21:0] DEG90_Q12  = 22'd368640;
    localparam logic [21:0] DEG180_Q12 = 22'd737280;
    localparam logic [21:0] DEG360_Q12 = 22'd1474560;

    // Arctangent of 2^-i in 1/4096 degree, rounded.
    localparam logic [19:0] ATAN_Q12 [CORDIC_STEPS] = '{
        20'd184320, 20'd108810, 20'd57492, 20'd29184, 20'd14649, 20'd7331,
        20'd3667, 20'd1833, 20'd917, 20'd458, 20'd229, 20'd115,
        20'd57, 20'd29, 20'd14, 20'd7
    };

    typedef enum logic [CFG_AW-1:0] {
        CFG_DIST_BINS  = 2'd0,
        CFG_ANGLE_BINS = 2'd1,
        CFG_ANGLE_LOW  = 2'd2,
        CFG_ANGLE_HIGH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
        logic [ANG_W-1:0] ang;
    } t_polar;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

// ===== hw/rtl/fphms_pair_if.sv =====
// ----------------------------------------------------------------------------
// fphms_pair_if
// Input channel: one matched point pair per beat.
// ----------------------------------------------------------------------------
interface fphms_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_first;
    logic [15:0] y_first;
    logic [15:0] x_second;
    logic [15:0] y_second;
    logic        set_end;

    modport source (output valid, x_first, y_first, x_second, y_second, set_end,
                    input ready);
    modport sink (input valid, x_first, y_first, x_second, y_second, set_end,
                  output ready);
endinterface

// ===== hw/rtl/fphms_res_if.sv =====
// ----------------------------------------------------------------------------
// fphms_res_if
// Output channel: one member index of the winning bin per beat.
// ----------------------------------------------------------------------------
interface fphms_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  point_index;
    logic [10:0] win_bin;
    logic [6:0]  win_count;
    logic        run_end;

    modport source (output valid, point_index, win_bin, win_count, run_end,
                    input ready);
    modport sink (input valid, point_index, win_bin, win_count, run_end,
                  output ready);
endinterface

// ===== hw/rtl/fphms_ram.sv =====
// ----------------------------------------------------------------------------
// fphms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fphms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/fphms_cordic.sv =====
// ----------------------------------------------------------------------------
// fphms_cordic
// Vectoring CORDIC, one micro-rotation per cycle, then gain correction.
// ----------------------------------------------------------------------------
module fphms_cordic import fphms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_dx,
    input  logic signed [16:0] i_dy,
    output t_polar             o_res
);
    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_ITER = 4'b0010,
        C_MUL  = 4'b0100,
        C_FIN  = 4'b1000
    } t_cstate;

    t_cstate            r_state;
    logic signed [31:0] r_x, r_y;
    logic signed [21:0] r_z;
    logic [3:0]         r_step;
    logic               r_zero, r_sx, r_sy;
    logic [46:0]        r_prod;
    t_polar             r_res;

    logic [15:0]        w_ax, w_ay;
    logic signed [31:0] w_xs, w_ys;
    logic signed [21:0] w_atan;
    logic [20:0]        w_zc;
    logic [21:0]        w_th;
    logic [15:0]        w_thr;
    logic [47:0]        w_sum;
    logic [19:0]        w_mq;

    assign w_ax   = i_dx[16] ? 16'(-i_dx) : i_dx[15:0];
    assign w_ay   = i_dy[16] ? 16'(-i_dy) : i_dy[15:0];
    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = 22'(ATAN_Q12[r_step]);

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > $signed(DEG90_Q12)) begin
            w_zc = DEG90_Q12[20:0];
        end else begin
            w_zc = r_z[20:0];
        end
        if (!r_sy) begin
            w_th = r_sx ? DEG360_Q12 - 22'(w_zc) : DEG180_Q12 + 22'(w_zc);
        end else begin
            w_th = r_sx ? 22'(w_zc) : DEG180_Q12 - 22'(w_zc);
        end
    end

    assign w_thr = 16'((w_th + 22'd32) >> 6);
    assign w_sum = 48'(r_prod) + 48'd134217728;
    assign w_mq  = w_sum[47:28];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= C_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x    <= 32'({w_ax, 12'd0});
                        r_y    <= 32'({w_ay, 12'd0});
                        r_z    <= '0;
                        r_step <= '0;
                        r_sx   <= i_dx[16];
                        r_sy   <= i_dy[16];
                        r_zero <= (i_dx == '0) && (i_dy == '0);
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_y[31]) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(CORDIC_STEPS - 1)) begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_prod  <= r_x[30:0] * INV_GAIN_Q16;
                    r_state <= C_FIN;
                end
                C_FIN: begin
                    r_res.done <= 1'b1;
                    if (r_zero) begin
                        r_res.mag <= '0;
                        r_res.ang <= ZERO_DISP_ANGLE;
                    end else begin
                        r_res.mag <= (w_mq > 20'(MAG_MAX_CODE)) ? MAG_MAX_CODE
                                                               : w_mq[16:0];
                        r_res.ang <= (w_thr > 16'(ANGLE_MAX_CODE)) ? ANGLE_MAX_CODE
                                                                  : w_thr[14:0];
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_res = r_res;
endmodule

// ===== hw/rtl/fphms_div.sv =====
// ----------------------------------------------------------------------------
// fphms_div
// Restoring divider, one quotient bit per cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module fphms_div import fphms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);
    logic             r_busy, r_done;
    logic [2:0]       r_k;
    logic [NUM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [24:0]      w_sh;
    logic             w_ge;

    assign w_sh = {8'd0, r_den} << r_k;
    assign w_ge = {2'd0, r_rem} >= w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_k    <= 3'd7;
                r_quo  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - w_sh[NUM_W-1:0];
                end
                r_quo[r_k] <= w_ge;
                r_k <= r_k - 3'd1;
                if (r_k == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
endmodule

// ===== hw/rtl/flow_polar_histogram_mode_select.sv =====
// ----------------------------------------------------------------------------
// flow_polar_histogram_mode_select
// Polar histogram of point-pair displacements, emits the fullest bin's members.
// ----------------------------------------------------------------------------
// Each accepted pair passes through the 16 CORDIC micro-rotations and gain
// correction before the input is ready again; the input is not ready meanwhile.
// The pair that ends a set adds a setup step, with a division on the shared
// divider when the direction bin count must be cut to fit the histogram, then
// binning of each stored pair (two divisions on the shared divider and a
// histogram read-modify-write), then emission and histogram cleanup of each
// stored pair, which waits while the output stalls. After reset the histogram
// memory is cleared before the first pair is accepted.
module flow_polar_histogram_mode_select import fphms_pkg::*; #(
    parameter int MAX_PAIRS  = DEF_MAX_PAIRS,
    parameter int HIST_DEPTH = DEF_HIST_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    fphms_pair_if.sink        i_pair,
    fphms_res_if.source       o_res
);
    localparam int PW = $clog2(MAX_PAIRS);
    localparam int HW = $clog2(HIST_DEPTH);

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_POL   = 13'b0000000000100,
        S_SETUP = 13'b0000000001000,
        S_AWAIT = 13'b0000000010000,
        S_RADDR = 13'b0000000100000,
        S_RDATA = 13'b0000001000000,
        S_DMAG  = 13'b0000010000000,
        S_DANG  = 13'b0000100000000,
        S_CRD   = 13'b0001000000000,
        S_CWR   = 13'b0010000000000,
        S_ERD   = 13'b0100000000000,
        S_EWR   = 13'b1000000000000
    } t_state;

    t_state           r_state;
    logic [4:0]       r_dist;
    logic [7:0]       r_abins;
    logic [14:0]      r_alow, r_ahigh;
    logic             r_set_end;
    logic [PW:0]      r_pc;
    logic [MAG_W-1:0] r_min, r_max;
    logic [PW-1:0]    r_idx;
    logic [HW-1:0]    r_clr;
    logic [4:0]       r_d, r_r;
    logic [7:0]       r_a;
    logic [HW-1:0]    r_b, r_win;
    logic [CNT_W-1:0] r_best, r_emit;
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [BIN_W-1:0] r_o_bin;
    logic [CNT_W-1:0] r_o_cnt;
    logic             r_o_end;

    logic               w_accept;
    logic signed [16:0] w_dx, w_dy;
    t_polar             w_polar;
    t_div_req           w_dreq;
    t_div_res           w_dres;
    logic               w_store_ok;
    logic [4:0]         w_dsat, w_rfin;
    logic [7:0]         w_asat, w_tfin;
    logic               w_a_big;
    logic [MAG_W-1:0]   w_span;
    logic               w_aspan_pos;
    logic [14:0]        w_aspan;
    logic [MAG_W-1:0]   w_mag_rd;
    logic [ANG_W-1:0]   w_ang_rd;
    logic [HW-1:0]      w_bop_rd;
    logic [CNT_W-1:0]   w_cnt_rd, w_cnt_new;
    logic [NUM_W-1:0]   w_mag_num, w_ang_num;
    logic [12:0]        w_b13;
    logic               w_better, w_match, w_can_load, w_last, w_load;
    logic               w_cnt_we;
    logic [HW-1:0]      w_cnt_waddr;
    logic [CNT_W-1:0]   w_cnt_wdata;

    assign w_accept = i_pair.valid && i_pair.ready;
    assign i_pair.ready = (r_state == S_IDLE);
    assign w_dx = $signed({1'b0, i_pair.x_first}) - $signed({1'b0, i_pair.x_second});
    assign w_dy = $signed({1'b0, i_pair.y_first}) - $signed({1'b0, i_pair.y_second});

    fphms_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_res   (w_polar)
    );

    fphms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_res   (w_dres)
    );

    assign w_store_ok = r_pc < (PW+1)'(MAX_PAIRS);

    fphms_ram #(.WIDTH(MAG_W), .DEPTH(MAX_PAIRS)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_POL) && w_polar.done && w_store_ok),
        .i_waddr (r_pc[PW-1:0]),
        .i_wdata (w_polar.mag),
        .i_raddr (r_idx),
        .o_rdata (w_mag_rd)
    );

    fphms_ram #(.WIDTH(ANG_W), .DEPTH(MAX_PAIRS)) u_ang_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_POL) && w_polar.done && w_store_ok),
        .i_waddr (r_pc[PW-1:0]),
        .i_wdata (w_polar.ang),
        .i_raddr (r_idx),
        .o_rdata (w_ang_rd)
    );

    fphms_ram #(.WIDTH(HW), .DEPTH(MAX_PAIRS)) u_bop_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CWR),
        .i_waddr (r_idx),
        .i_wdata (r_b),
        .i_raddr (r_idx),
        .o_rdata (w_bop_rd)
    );

    fphms_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_b),
        .o_rdata (w_cnt_rd)
    );

    // Effective bin counts, saturated into range.
    assign w_dsat = (r_dist == '0) ? 5'd1 : ((r_dist > 5'd16) ? 5'd16 : r_dist);
    assign w_asat = (r_abins == '0) ? 8'd1 : ((r_abins > 8'd128) ? 8'd128 : r_abins);
    assign w_a_big = ({5'd0, w_asat} * {8'd0, w_dsat}) > 13'(HIST_DEPTH);

    assign w_span      = r_max - r_min;
    assign w_aspan_pos = r_ahigh > r_alow;
    assign w_aspan     = r_ahigh - r_alow;
    assign w_mag_num   = (w_mag_rd - r_min) * r_d;
    assign w_ang_num   = (w_ang_rd - r_alow) * r_a;

    always_comb begin
        w_dreq = '0;
        if (r_state == S_SETUP) begin
            w_dreq.start = w_a_big;
            w_dreq.num   = NUM_W'(HIST_DEPTH);
            w_dreq.den   = MAG_W'(w_dsat);
        end else if (r_state == S_RDATA) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = w_mag_num;
            w_dreq.den   = w_span;
        end else if (r_state == S_DMAG) begin
            w_dreq.start = w_dres.done;
            w_dreq.num   = w_ang_num;
            w_dreq.den   = MAG_W'(w_aspan);
        end
    end

    always_comb begin
        if (w_span == '0) begin
            w_rfin = '0;
        end else if (w_dres.quo > {3'd0, r_d - 5'd1}) begin
            w_rfin = r_d - 5'd1;
        end else begin
            w_rfin = w_dres.quo[4:0];
        end
        // Below the range and an empty range both land in bin 0; at or
        // above the upper end the quotient would overflow, so clamp early.
        if (!w_aspan_pos || (w_ang_rd <= r_alow)) begin
            w_tfin = '0;
        end else if ((w_ang_rd >= r_ahigh) || (w_dres.quo > r_a - 8'd1)) begin
            w_tfin = r_a - 8'd1;
        end else begin
            w_tfin = w_dres.quo;
        end
    end

    assign w_b13     = ({5'd0, w_tfin} * {8'd0, r_d}) + {8'd0, r_r};
    assign w_cnt_new = w_cnt_rd + 7'd1;
    // Counts only grow, so a running max with lowest-index tie-break
    // ends on the first fullest bin.
    assign w_better  = (w_cnt_new > r_best) || ((w_cnt_new == r_best) && (r_b < r_win));
    assign w_match   = (w_bop_rd == r_win);
    assign w_can_load = !r_o_valid || o_res.ready;
    assign w_last    = ({1'b0, r_idx} + (PW+1)'(1)) == r_pc;
    assign w_load    = (r_state == S_EWR) && w_match && w_can_load;

    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_clr;
        w_cnt_wdata = '0;
        if (r_state == S_CLR) begin
            w_cnt_we = 1'b1;
        end else if (r_state == S_CWR) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_b;
            w_cnt_wdata = w_cnt_new;
        end else if (r_state == S_EWR) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = w_bop_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_dist    <= RST_DIST_BINS;
            r_abins   <= RST_ANGLE_BINS;
            r_alow    <= RST_ANGLE_LOW;
            r_ahigh   <= RST_ANGLE_HIGH;
            r_pc      <= '0;
            r_min     <= MAG_MAX_CODE;
            r_max     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_DIST_BINS:  r_dist  <= i_cfg_wdata[4:0];
                    CFG_ANGLE_BINS: r_abins <= i_cfg_wdata[7:0];
                    CFG_ANGLE_LOW:  r_alow  <= i_cfg_wdata[14:0];
                    CFG_ANGLE_HIGH: r_ahigh <= i_cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (w_load) begin
                r_o_valid <= 1'b1;
                r_o_idx   <= IDX_W'(r_idx);
                r_o_bin   <= BIN_W'(r_win);
                r_o_cnt   <= r_best;
                r_o_end   <= (r_emit + 7'd1) == r_best;
                r_emit    <= r_emit + 7'd1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + HW'(1);
                    if (r_clr == HW'(HIST_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_set_end <= i_pair.set_end;
                        r_state   <= S_POL;
                    end
                end
                S_POL: begin
                    if (w_polar.done) begin
                        if (w_store_ok) begin
                            r_pc <= r_pc + (PW+1)'(1);
                            if (w_polar.mag < r_min) begin
                                r_min <= w_polar.mag;
                            end
                            if (w_polar.mag > r_max) begin
                                r_max <= w_polar.mag;
                            end
                        end
                        r_state <= r_set_end ? S_SETUP : S_IDLE;
                    end
                end
                S_SETUP: begin
                    r_d    <= w_dsat;
                    r_best <= '0;
                    r_win  <= '0;
                    r_idx  <= '0;
                    r_emit <= '0;
                    if (w_a_big) begin
                        r_state <= S_AWAIT;
                    end else begin
                        r_a     <= w_asat;
                        r_state <= S_RADDR;
                    end
                end
                S_AWAIT: begin
                    if (w_dres.done) begin
                        r_a     <= w_dres.quo;
                        r_state <= S_RADDR;
                    end
                end
                S_RADDR: r_state <= S_RDATA;
                S_RDATA: r_state <= S_DMAG;
                S_DMAG: begin
                    if (w_dres.done) begin
                        r_r     <= w_rfin;
                        r_state <= S_DANG;
                    end
                end
                S_DANG: begin
                    if (w_dres.done) begin
                        r_b     <= w_b13[HW-1:0];
                        r_state <= S_CRD;
                    end
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    if (w_better) begin
                        r_best <= w_cnt_new;
                        r_win  <= r_b;
                    end
                    if (w_last) begin
                        r_idx   <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_idx   <= r_idx + PW'(1);
                        r_state <= S_RADDR;
                    end
                end
                S_ERD: r_state <= S_EWR;
                S_EWR: begin
                    if (!w_match || w_can_load) begin
                        if (w_last) begin
                            r_pc    <= '0;
                            r_min   <= MAG_MAX_CODE;
                            r_max   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + PW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.point_index = r_o_idx;
    assign o_res.win_bin     = r_o_bin;
    assign o_res.win_count   = r_o_cnt;
    assign o_res.run_end     = r_o_end;
endmodule

// ===== hw/rtl/fphms_checker.sv =====
// ----------------------------------------------------------------------------
// fphms_checker
// Port-level checks of the mode filter, bound to the top level.
// ----------------------------------------------------------------------------
module fphms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_point_index,
    input logic [10:0] i_win_bin,
    input logic [6:0]  i_win_count,
    input logic        i_run_end
);
    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_point_index) && $stable(i_win_bin)
             && $stable(i_win_count) && $stable(i_run_end)))
        else $error("result beat changed while stalled");

    // Each pair occupies the CORDIC, so the input closes after a beat.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted pair");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_win_count != 7'd0))
        else $error("result beat with empty winning bin");

    // A beat that is not the last of its run implies another member.
    a_run_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_run_end) |-> (i_win_count > 7'd1))
        else $error("run continues past a single-member bin");
endmodule

bind flow_polar_histogram_mode_select fphms_checker u_fphms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pair.valid),
    .i_in_ready    (i_pair.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_point_index (o_res.point_index),
    .i_win_bin     (o_res.win_bin),
    .i_win_count   (o_res.win_count),
    .i_run_end     (o_res.run_end)
);

// ===== sim/flow_polar_histogram_mode_select_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_polar_histogram_mode_select_tb
// Feeds sets of matched point pairs through the polar histogram mode filter
// and checks every emitted member index against a local polar-binning model.
// ----------------------------------------------------------------------------
module flow_polar_histogram_mode_select_tb;
    import fphms_pkg::*;

    localparam int MAX_PAIRS_TB = 64;

    typedef struct packed {
        logic [15:0] x_first;
        logic [15:0] y_first;
        logic [15:0] x_second;
        logic [15:0] y_second;
        logic        set_end;
    } t_pair;

    typedef struct packed {
        logic [5:0]  point_index;
        logic [10:0] win_bin;
        logic [6:0]  win_count;
        logic        run_end;
    } t_member;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;

    fphms_pair_if pair ();
    fphms_res_if  res ();

    flow_polar_histogram_mode_select DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pair      (pair.sink),
        .o_res       (res.source)
    );

    t_pair   pending_pairs[$];
    t_member member_q[$];
    t_pair   cur_pair;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      mismatches;
    int      failures;

    // Local copy of the registers and of the per-set state.
    int unsigned dist_bins_r, angle_bins_r, angle_low_r, angle_high_r;
    int unsigned set_mag[MAX_PAIRS_TB];
    int unsigned set_ang[MAX_PAIRS_TB];
    int unsigned set_bin[MAX_PAIRS_TB];
    int unsigned hist[2048];
    int unsigned set_size, set_mag_min, set_mag_max;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void polar_of(input longint dx, input longint dy,
                                     output int unsigned mag, output int unsigned ang);
        longint x, y, z, xs, ys, th;
        longint unsigned m;
        z = 0;
        if (dx == 0 && dy == 0) begin
            mag = 0;
            ang = ZERO_DISP_ANGLE;
            return;
        end
        x = (dx < 0 ? -dx : dx) <<< 12;
        y = (dy < 0 ? -dy : dy) <<< 12;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(ATAN_Q12[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(ATAN_Q12[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(DEG90_Q12)) z = DEG90_Q12;
        if (dy >= 0)
            th = (dx >= 0) ? longint'(DEG180_Q12) + z : longint'(DEG360_Q12) - z;
        else
            th = (dx < 0) ? z : longint'(DEG180_Q12) - z;
        th = (th + 32) >>> 6;
        if (th > longint'(ANGLE_MAX_CODE)) th = ANGLE_MAX_CODE;
        ang = int'(th);
        m = (longint'(x) * 39797 + (64'd1 << 27)) >> 28;
        mag = (m > 131071) ? 131071 : int'(m);
    endfunction

    function automatic void clear_set();
        set_size = 0;
        set_mag_min = 131071;
        set_mag_max = 0;
    endfunction

    // Accepts one pair; on the end of a set, bins every stored pair and queues
    // the members of the first fullest bin.
    function automatic void accept_pair(input t_pair p);
        int unsigned mag, ang, d, a, span, aspan, total, win, best, r, t, b, n;
        t_member mb;
        polar_of(longint'(p.x_first) - longint'(p.x_second),
                 longint'(p.y_first) - longint'(p.y_second), mag, ang);
        if (set_size < MAX_PAIRS_TB) begin
            set_mag[set_size] = mag;
            set_ang[set_size] = ang;
            if (mag < set_mag_min) set_mag_min = mag;
            if (mag > set_mag_max) set_mag_max = mag;
            set_size++;
        end
        if (!p.set_end) return;
        d = dist_bins_r < 1 ? 1 : (dist_bins_r > 16 ? 16 : dist_bins_r);
        a = angle_bins_r < 1 ? 1 : (angle_bins_r > 128 ? 128 : angle_bins_r);
        if (a > 2048 / d) a = 2048 / d;
        total = a * d;
        span = set_mag_max >= set_mag_min ? set_mag_max - set_mag_min : 0;
        aspan = angle_high_r > angle_low_r ? angle_high_r - angle_low_r : 0;
        for (int k = 0; k < 2048; k++) hist[k] = 0;
        for (int i = 0; i < set_size; i++) begin
            r = 0;
            t = 0;
            if (span > 0 && set_mag[i] >= set_mag_min) begin
                r = ((set_mag[i] - set_mag_min) * d) / span;
                if (r > d - 1) r = d - 1;
            end
            if (aspan > 0 && set_ang[i] > angle_low_r) begin
                t = ((set_ang[i] - angle_low_r) * a) / aspan;
                if (t > a - 1) t = a - 1;
            end
            b = t * d + r;
            if (b >= 2048) b = 2047;
            set_bin[i] = b;
            if (hist[b] < 127) hist[b]++;
        end
        best = hist[0];
        win = 0;
        for (int k = 1; k < total && k < 2048; k++)
            if (hist[k] > best) begin
                best = hist[k];
                win = k;
            end
        n = 0;
        for (int i = 0; i < set_size; i++)
            if (set_bin[i] == win) n++;
        for (int i = 0; i < set_size; i++)
            if (set_bin[i] == win) begin
                n--;
                mb.point_index = i[5:0];
                mb.win_bin = win[10:0];
                mb.win_count = best[6:0];
                mb.run_end = (n == 0);
                member_q.insert(member_q.size(), mb);
            end
        clear_set();
    endfunction

    // Pair driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair.valid <= 1'b0;
            {pair.x_first, pair.y_first, pair.x_second, pair.y_second, pair.set_end} <= '0;
        end else begin
            if (pair.valid && pair.ready) accept_pair(cur_pair);
            if (!pair.valid || pair.ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_pair = pending_pairs.pop_front();
                    pair.valid <= 1'b1;
                    {pair.x_first, pair.y_first, pair.x_second, pair.y_second,
                     pair.set_end} <= cur_pair;
                end else begin
                    pair.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_member got, want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (res.valid && res.ready) begin
                got = {res.point_index, res.win_bin, res.win_count, res.run_end};
                if (member_q.size() == 0) begin
                    failures++;
                    if (mismatches < 10)
                        $display("Unexpected member beat: expected none, got idx %0d %s",
                                 got.point_index,
                                 $sformatf("bin %0d cnt %0d end %0d",
                                           got.win_bin, got.win_count, got.run_end));
                    mismatches++;
                end else begin
                    want = member_q.pop_front();
                    if (got != want) begin
                        failures++;
                        if (mismatches < 10)
                            $display({"Member mismatch: expected idx %0d bin %0d cnt %0d",
                                      " end %0d, got idx %0d bin %0d cnt %0d end %0d"},
                                     want.point_index, want.win_bin, want.win_count,
                                     want.run_end, got.point_index, got.win_bin,
                                     got.win_count, got.run_end);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic add_pair(input int x1, input int y1, input int x2, input int y2,
                            input bit last);
        t_pair p;
        p.x_first = x1[15:0];
        p.y_first = y1[15:0];
        p.x_second = x2[15:0];
        p.y_second = y2[15:0];
        p.set_end = last;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // A set of motion vectors drawn mostly from a few clusters, so that
    // the fullest bin is usually a real mode with several members.
    task automatic add_random_set(input int n);
        int cdx[3], cdy[3], x1, y1, c;
        for (int k = 0; k < 3; k++) begin
            cdx[k] = $urandom_range(4000) - 2000;
            cdy[k] = $urandom_range(4000) - 2000;
        end
        for (int i = 0; i < n; i++) begin
            x1 = $urandom_range(65535);
            y1 = $urandom_range(65535);
            if ($urandom_range(99) < 20) begin
                add_pair(x1, y1, $urandom_range(65535), $urandom_range(65535), i == n - 1);
            end else begin
                c = $urandom_range(2);
                add_pair(x1, y1, x1 - cdx[c] - ($urandom_range(40) - 20),
                         y1 - cdy[c] - ($urandom_range(40) - 20), i == n - 1);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DIST_BINS:  dist_bins_r = val & 32'h1F;
            CFG_ANGLE_BINS: angle_bins_r = val & 32'hFF;
            CFG_ANGLE_LOW:  angle_low_r = val & 32'h7FFF;
            CFG_ANGLE_HIGH: angle_high_r = val & 32'h7FFF;
        endcase
    endtask

    task automatic set_regs(input int unsigned d, input int unsigned a,
                            input int unsigned lo, input int unsigned hi);
        write_reg(CFG_DIST_BINS, d);
        write_reg(CFG_ANGLE_BINS, a);
        write_reg(CFG_ANGLE_LOW, lo);
        write_reg(CFG_ANGLE_HIGH, hi);
    endtask

    // Waits until every queued pair is taken and every member has come back,
    // then lets the cleanup after the last set run out.
    task automatic drain();
        while (pending_pairs.size() > 0 || pair.valid || member_q.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        #6000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int left;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        res.ready = 1'b0;
        pair.valid = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 68;
        mismatches = 0;
        failures = 0;
        dist_bins_r = 10;
        angle_bins_r = 90;
        angle_low_r = 0;
        angle_high_r = 23040;
        clear_set();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every quadrant, both axes, zero displacement, extremes.
        add_pair(16'h1234, 16'h4321, 16'h1234, 16'h4321, 0);
        add_pair(16'hFFFF, 16'hFFFF, 0, 0, 0);
        add_pair(0, 0, 16'hFFFF, 16'hFFFF, 0);
        add_pair(16'hFFFF, 0, 0, 16'hFFFF, 0);
        add_pair(0, 16'hFFFF, 16'hFFFF, 0, 0);
        add_pair(300, 50, 0, 50, 0);
        add_pair(0, 50, 300, 50, 0);
        add_pair(50, 300, 50, 0, 0);
        add_pair(50, 0, 50, 300, 0);
        add_pair(400, 400, 100, 100, 0);
        add_pair(400, 400, 100, 100, 1);
        // A lone pair: minimum equals maximum.
        add_pair(1000, 2000, 900, 1900, 1);
        // Only zero displacements.
        add_pair(7, 7, 7, 7, 0);
        add_pair(9, 9, 9, 9, 1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 68 : 0;
            recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 13 : 0;
            for (int c = 0; c < 3; c++) begin
                case (ph * 3 + c)
                    0: set_regs(16, 128, 0, 23040);
                    1: set_regs(1, 1, 0, 23040);
                    2: set_regs(0, 0, 5000, 20000);
                    3: set_regs(31, 255, 100, 32767);
                    4: set_regs(4, 8, 20000, 3000);
                    5: set_regs(7, 33, 11520, 11521);
                    6: set_regs(10, 90, 0, 23040);
                    default: set_regs($urandom_range(17), $urandom_range(130),
                                      $urandom_range(12000), $urandom_range(23040));
                endcase
                left = 21;
                while (left > 0) begin
                    int n;
                    n = $urandom_range(12, 1);
                    if (n > left) n = left;
                    add_random_set(n);
                    left -= n;
                end
                // One set that overflows the store; its end lands on a dropped pair.
                if (ph == 2 && c == 0) add_random_set(67);
                drain();
            end
        end

        if (failures == 0 && member_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
